// ----- src/spva_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spva_pkg: sprite pixel VRAM address package
// Shared types and constants for the sprite fetch address pipeline.
// ----------------------------------------------------------------------------
package spva_pkg;

  localparam int MAX_SIDE_DEF = 128;
  localparam int COORD_W      = 7;
  localparam int ADDR_W       = 20;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int PIPE_LATENCY = 5;

  localparam logic [COORD_W-1:0] SIDE_RST = 7'd8;

  // sprite_flags bit positions
  localparam int FLAG_ROT    = 0;
  localparam int FLAG_DBL    = 1;
  localparam int FLAG_FOUR   = 2;
  localparam int FLAG_BMP    = 3;
  localparam int FLAG_MOSAIC = 4;
  localparam int FLAG_HFLIP  = 5;
  localparam int FLAG_VFLIP  = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_PX     = 3'd0,
    REG_HEIGHT_PX    = 3'd1,
    REG_SPRITE_FLAGS = 3'd2,
    REG_TILE_BASE    = 3'd3,
    REG_ROW_SHIFT    = 3'd4,
    REG_MAPPING_MODE = 3'd5,
    REG_MOSAIC_SIZE  = 3'd6,
    REG_AFFINE       = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FETCH_NONE   = 2'd0,
    FETCH_BYTE   = 2'd1,
    FETCH_NIBBLE = 2'd2,
    FETCH_DIRECT = 2'd3
  } fetch_kind_t;

  typedef enum logic [1:0] {
    LAYOUT_2D_128 = 2'd0,
    LAYOUT_2D_256 = 2'd1,
    LAYOUT_1D     = 2'd2,
    LAYOUT_UNDEF  = 2'd3
  } bmp_layout_t;

endpackage

// ----- src/sprite_pixel_vram_address.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_pixel_vram_address: sprite pixel fetch address pipeline
// Maps a sprite-local pixel to its object VRAM byte address and fetch kind,
// for tiled and bitmap sprites, in normal and affine modes.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write cfg_data to register cfg_index while cfg_write is
//   high (0 width, 1 height, 2 flags, 3 tile base, 4 row shift, 5 mapping
//   mode, 6 mosaic size, 7 affine matrix). Write only while the pipe is empty.
//   Input: a transaction is taken at a rising edge with start high and busy
//   low. busy is high only while rst is held, so one pixel may enter in every
//   cycle.
//   Output: done strobes for one cycle with byte_address, fetch_kind and
//   nibble_high. A transaction passes five register stages (input/mosaic,
//   mosaic/multiply, sum/flip, bounds, address); throughput is one
//   transaction per cycle.
//   Reset: synchronous rst clears the configuration to its defaults (8x8,
//   all else zero) and drops every transaction in flight.
//   The receiver cannot stall: done is presented once and never held.
// ----------------------------------------------------------------------------
module sprite_pixel_vram_address #(
  parameter int MAX_SIDE = spva_pkg::MAX_SIDE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [spva_pkg::COORD_W-1:0]        pixel_x,
  input  logic [spva_pkg::COORD_W-1:0]        pixel_y,
  output logic                                done,
  output logic [spva_pkg::ADDR_W-1:0]         byte_address,
  output logic [1:0]                          fetch_kind,
  output logic                                nibble_high,
  input  logic                                cfg_write,
  input  logic [spva_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spva_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [7:0] SIDE_CAP = 8'(MAX_SIDE);

  // configuration registers
  logic [6:0]  width_px;
  logic [6:0]  height_px;
  logic [6:0]  sprite_flags;
  logic [9:0]  tile_base;
  logic [3:0]  row_shift;
  logic [4:0]  mapping_mode;
  logic [7:0]  mosaic_size;
  logic [63:0] affine_matrix;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_px      <= spva_pkg::SIDE_RST;
      height_px     <= spva_pkg::SIDE_RST;
      sprite_flags  <= '0;
      tile_base     <= '0;
      row_shift     <= '0;
      mapping_mode  <= '0;
      mosaic_size   <= '0;
      affine_matrix <= '0;
    end else if (cfg_write) begin
      unique case (spva_pkg::cfg_reg_t'(cfg_index))
        spva_pkg::REG_WIDTH_PX:     width_px      <= cfg_data[6:0];
        spva_pkg::REG_HEIGHT_PX:    height_px     <= cfg_data[6:0];
        spva_pkg::REG_SPRITE_FLAGS: sprite_flags  <= cfg_data[6:0];
        spva_pkg::REG_TILE_BASE:    tile_base     <= cfg_data[9:0];
        spva_pkg::REG_ROW_SHIFT:    row_shift     <= cfg_data[3:0];
        spva_pkg::REG_MAPPING_MODE: mapping_mode  <= cfg_data[4:0];
        spva_pkg::REG_MOSAIC_SIZE:  mosaic_size   <= cfg_data[7:0];
        spva_pkg::REG_AFFINE:       affine_matrix <= cfg_data;
      endcase
    end
  end

  // decoded configuration
  logic rot, dbl, four, bmp, hflip, vflip;
  logic [3:0] mos_x, mos_y;
  logic mos_x_en, mos_y_en;
  logic [7:0] area_w, area_h;
  logic [6:0] ctr_x, ctr_y;
  spva_pkg::bmp_layout_t layout;
  logic signed [15:0] pa, pb, pc, pd;

  assign rot      = sprite_flags[spva_pkg::FLAG_ROT];
  assign dbl      = sprite_flags[spva_pkg::FLAG_DBL];
  assign four     = sprite_flags[spva_pkg::FLAG_FOUR];
  assign bmp      = sprite_flags[spva_pkg::FLAG_BMP];
  assign hflip    = sprite_flags[spva_pkg::FLAG_HFLIP];
  assign vflip    = sprite_flags[spva_pkg::FLAG_VFLIP];
  assign mos_x    = mosaic_size[3:0];
  assign mos_y    = mosaic_size[7:4];
  assign mos_x_en = sprite_flags[spva_pkg::FLAG_MOSAIC] && (mos_x != 4'd0);
  assign mos_y_en = sprite_flags[spva_pkg::FLAG_MOSAIC] && (mos_y != 4'd0);
  assign area_w   = (rot && dbl) ? {width_px, 1'b0} : {1'b0, width_px};
  assign area_h   = (rot && dbl) ? {height_px, 1'b0} : {1'b0, height_px};
  assign ctr_x    = area_w[7:1];
  assign ctr_y    = area_h[7:1];
  assign layout   = spva_pkg::bmp_layout_t'(mapping_mode[1:0]);
  assign pa       = $signed(affine_matrix[15:0]);
  assign pb       = $signed(affine_matrix[31:16]);
  assign pc       = $signed(affine_matrix[47:32]);
  assign pd       = $signed(affine_matrix[63:48]);

  assign busy = rst;

  // one conditional subtract of the restoring remainder
  function automatic logic [6:0] mod_step(input logic [6:0] v, input logic [3:0] m,
                                          input int sh);
    logic [10:0] d;
    d = 11'(m) << sh;
    mod_step = (11'(v) >= d) ? 7'(11'(v) - d) : v;
  endfunction

  // ---------------- stage 0 -> 1: area check, center, mosaic high bits
  logic       s1_valid, s1_miss;
  logic [6:0] s1_px, s1_py, s1_rx, s1_ry;
  logic signed [7:0] s1_dx, s1_dy;

  logic       s0_miss;
  logic [6:0] s0_rx, s0_ry;
  logic signed [7:0] s0_dx, s0_dy;

  always_comb begin
    s0_miss = (dbl && !rot) ||
              ({1'b0, pixel_x} >= area_w) || ({1'b0, pixel_x} >= SIDE_CAP) ||
              ({1'b0, pixel_y} >= area_h) || ({1'b0, pixel_y} >= SIDE_CAP);
    s0_dx = $signed({1'b0, pixel_x}) - $signed({1'b0, ctr_x});
    s0_dy = $signed({1'b0, pixel_y}) - $signed({1'b0, ctr_y});
    s0_rx = pixel_x;
    s0_ry = pixel_y;
    for (int i = 6; i >= 4; i--) begin
      s0_rx = mod_step(s0_rx, mos_x, i);
      s0_ry = mod_step(s0_ry, mos_y, i);
    end
  end

  // ---------------- stage 1 -> 2: mosaic low bits, affine products
  logic       s2_valid, s2_miss;
  logic [6:0] s2_xx, s2_yy;
  logic signed [23:0] s2_pa, s2_pb, s2_pc, s2_pd;

  logic [6:0] s1_rx_f, s1_ry_f, s1_xx, s1_yy;
  logic signed [23:0] s1_pa, s1_pb, s1_pc, s1_pd;

  always_comb begin
    s1_rx_f = s1_rx;
    s1_ry_f = s1_ry;
    for (int i = 3; i >= 0; i--) begin
      s1_rx_f = mod_step(s1_rx_f, mos_x, i);
      s1_ry_f = mod_step(s1_ry_f, mos_y, i);
    end
    s1_xx = mos_x_en ? (s1_px - s1_rx_f) : s1_px;
    s1_yy = mos_y_en ? (s1_py - s1_ry_f) : s1_py;
    s1_pa = 24'(s1_dx) * 24'(pa);
    s1_pb = 24'(s1_dy) * 24'(pb);
    s1_pc = 24'(s1_dx) * 24'(pc);
    s1_pd = 24'(s1_dy) * 24'(pd);
  end

  // ---------------- stage 2 -> 3: flips, affine sums
  logic       s3_valid, s3_miss;
  logic [6:0] s3_xf, s3_yf;
  logic signed [17:0] s3_x3, s3_y3;

  logic [6:0] s2_xf, s2_yf;
  logic signed [24:0] s2_sum_x, s2_sum_y;
  logic signed [17:0] s2_x3, s2_y3;

  always_comb begin
    s2_xf    = hflip ? (width_px - 7'd1 - s2_xx) : s2_xx;
    s2_yf    = vflip ? (height_px - 7'd1 - s2_yy) : s2_yy;
    s2_sum_x = 25'(s2_pa) + 25'(s2_pb);
    s2_sum_y = 25'(s2_pc) + 25'(s2_pd);
    s2_x3    = 18'(s2_sum_x >>> 8) + 18'($signed({1'b0, width_px[6:1]}));
    s2_y3    = 18'(s2_sum_y >>> 8) + 18'($signed({1'b0, height_px[6:1]}));
  end

  // ---------------- stage 3 -> 4: bounds, source coordinate select
  logic       s4_valid, s4_miss;
  logic [6:0] s4_ux, s4_uy;

  logic       s3_oob, s3_miss_n;
  logic [6:0] s3_ux, s3_uy;

  always_comb begin
    s3_oob = s3_x3[17] || s3_y3[17] ||
             (s3_x3 >= $signed({11'd0, width_px})) ||
             (s3_y3 >= $signed({11'd0, height_px}));
    s3_miss_n = s3_miss || (rot && s3_oob) || (bmp && (layout == spva_pkg::LAYOUT_UNDEF));
    s3_ux = rot ? s3_x3[6:0] : s3_xf;
    s3_uy = rot ? s3_y3[6:0] : s3_yf;
  end

  // ---------------- stage 4 -> 5: address
  logic [19:0] s4_base, s4_row, s4_tile_row, s4_addr;
  logic [4:0]  s4_rs;
  logic [1:0]  s4_kind;
  logic        s4_nib;

  always_comb begin
    s4_rs       = rot ? (5'(row_shift) + 5'd1) : 5'(row_shift);
    s4_base     = '0;
    s4_row      = '0;
    s4_tile_row = ((20'(tile_base) << mapping_mode[3:2]) +
                   (20'(s4_uy[6:3]) << row_shift)) << 5;
    unique case (layout)
      spva_pkg::LAYOUT_2D_128: begin
        s4_base = (20'(tile_base[3:0]) << 4) + (20'(tile_base[9:4]) << 11);
        s4_row  = 20'(s4_uy) << 8;
      end
      spva_pkg::LAYOUT_2D_256: begin
        s4_base = (20'(tile_base[4:0]) << 4) + (20'(tile_base[9:5]) << 12);
        s4_row  = 20'(s4_uy) << 9;
      end
      spva_pkg::LAYOUT_1D: begin
        s4_base = 20'(tile_base) << (mapping_mode[4] ? 4'd8 : 4'd7);
        s4_row  = 20'(s4_uy) << s4_rs;
      end
      spva_pkg::LAYOUT_UNDEF: begin
        s4_base = '0;
        s4_row  = '0;
      end
    endcase
    s4_nib = 1'b0;
    if (s4_miss) begin
      s4_kind = spva_pkg::FETCH_NONE;
      s4_addr = '0;
    end else if (bmp) begin
      s4_kind = spva_pkg::FETCH_DIRECT;
      s4_addr = s4_base + s4_row + (20'(s4_ux) << 1);
    end else if (!four) begin
      s4_kind = spva_pkg::FETCH_BYTE;
      s4_addr = s4_tile_row + (20'(s4_uy[2:0]) << 3) + (20'(s4_ux[6:3]) << 6) +
                20'(s4_ux[2:0]);
    end else begin
      s4_kind = spva_pkg::FETCH_NIBBLE;
      s4_nib  = s4_ux[0];
      s4_addr = s4_tile_row + (20'(s4_uy[2:0]) << 2) + (20'(s4_ux[6:3]) << 5) +
                20'(s4_ux[2:1]);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      done     <= s4_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    s1_miss      <= s0_miss;
    s1_px        <= pixel_x;
    s1_py        <= pixel_y;
    s1_rx        <= s0_rx;
    s1_ry        <= s0_ry;
    s1_dx        <= s0_dx;
    s1_dy        <= s0_dy;

    s2_miss      <= s1_miss;
    s2_xx        <= s1_xx;
    s2_yy        <= s1_yy;
    s2_pa        <= s1_pa;
    s2_pb        <= s1_pb;
    s2_pc        <= s1_pc;
    s2_pd        <= s1_pd;

    s3_miss      <= s2_miss;
    s3_xf        <= s2_xf;
    s3_yf        <= s2_yf;
    s3_x3        <= s2_x3;
    s3_y3        <= s2_y3;

    s4_miss      <= s3_miss_n;
    s4_ux        <= s3_ux;
    s4_uy        <= s3_uy;

    byte_address <= s4_addr;
    fetch_kind   <= s4_kind;
    nibble_high  <= s4_nib;
  end

endmodule

// ----- src/spva_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spva_checker: port checks for the sprite fetch address pipeline
// Latency and result encoding checks, bound to the top level.
// ----------------------------------------------------------------------------
module spva_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [spva_pkg::ADDR_W-1:0]  byte_address,
  input logic [1:0]                   fetch_kind,
  input logic                         nibble_high
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("transaction accepted without a result five cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without a matching accepted transaction");

  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (fetch_kind == spva_pkg::FETCH_NONE)) |->
      ((byte_address == '0) && !nibble_high))
    else $error("empty fetch carries address or nibble select");

  a_nibble_kind: assert property (@(posedge clk) disable iff (rst)
    (done && nibble_high) |-> (fetch_kind == spva_pkg::FETCH_NIBBLE))
    else $error("nibble select set on a non-nibble fetch");

endmodule

bind sprite_pixel_vram_address spva_checker u_spva_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .byte_address (byte_address),
  .fetch_kind   (fetch_kind),
  .nibble_high  (nibble_high)
);
